### rtl/hhhl_pkg.sv
// ----------------------------------------------------------------------------
// hhhl_pkg: shared definitions for the hashed heavy-hitter limiter
// table geometry, generator constants and sequencer states
// ----------------------------------------------------------------------------
package hhhl_pkg;

    localparam int INDEX_BITS     = 10;
    localparam int SLOTS_PER_LINE = 15;
    localparam int LINE_CHOICES   = 2;

    localparam int TAG_BITS   = 16;
    localparam int LOAD_BITS  = 16;
    localparam int ENTRY_BITS = TAG_BITS + LOAD_BITS;

    localparam int ROW_COUNT   = 1 << INDEX_BITS;
    localparam int STORE_DEPTH = ROW_COUNT * LINE_CHOICES * SLOTS_PER_LINE;
    localparam int ADDR_BITS   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SLOT_BITS   = (SLOTS_PER_LINE > 1) ? $clog2(SLOTS_PER_LINE) : 1;
    localparam int LINE_BITS   = (LINE_CHOICES > 1) ? $clog2(LINE_CHOICES) : 1;
    localparam int TAG_LSB     = LINE_CHOICES * INDEX_BITS;

    localparam logic [63:0] RNG_SEED = 64'd3723796604792068981;
    localparam logic [63:0] RNG_MUL  = 64'd11737314301796036329;
    localparam logic [63:0] RNG_ADD  = 64'd3107264277052274849;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RNG_LO,
        ST_RNG_X1,
        ST_RNG_X2,
        ST_RNG_ADD,
        ST_ROUND,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } hhhl_state_t;

endpackage

### rtl/hhhl_ram.sv
// ----------------------------------------------------------------------------
// hhhl_ram: generic single-write, single-read memory
// one write port and one read port with registered read data
// ----------------------------------------------------------------------------
module hhhl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/hashed_heavy_hitter_limiter_unit.sv
// ----------------------------------------------------------------------------
// hashed_heavy_hitter_limiter_unit: two-choice heavy-hitter load limiter
// per-query tag search, smallest-load takeover and load accounting
// ----------------------------------------------------------------------------
// usage
//   s_* channel takes one query request: key hash and fixed-point price
//   m_* channel returns one result per query: limited and found flags
//   the hash picks one line of slots in each table plus a tag; the tag is
//   searched in both lines, on a miss the first least-loaded slot is taken
// timing
//   after reset a clearing pass zeroes the slot store, one entry per cycle,
//   all STORE_DEPTH entries (30720 as configured); s_tready stays low meanwhile
//   each query is worked through by a small sequencer: one store read per
//   slot, then one write-back; when the price has a nonzero fraction, the
//   64-bit generator step first runs through one shared 32x32 multiplier
//   in three passes, then a final add and a rounding step
//   the result sits in an output register; the block takes the next query
//   while it waits, and only holds the following result back if m_tready
//   is still low by then
// ----------------------------------------------------------------------------
module hashed_heavy_hitter_limiter_unit
    import hhhl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // key_hash [63:0], price [95:64]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // limited [0], found [1], zero [7:2]
);

    // sequencer state
    hhhl_state_t state_reg, state_next;

    // query registers
    logic [63:0]          hash_reg, hash_next;
    logic [15:0]          price16_reg, price16_next;
    logic [15:0]          limit16_reg, limit16_next;
    logic [15:0]          fract_reg, fract_next;

    // rounding generator and multiplier accumulator
    logic [63:0]          rng_reg, rng_next;
    logic [63:0]          acc_reg, acc_next;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          mul_prod;

    // clearing pass
    logic [ADDR_BITS-1:0] clear_addr_reg, clear_addr_next;
    logic                 clear_last;

    // scan issue side
    logic [LINE_BITS-1:0] issue_line_reg, issue_line_next;
    logic [SLOT_BITS-1:0] issue_slot_reg, issue_slot_next;
    logic                 issue_done_reg, issue_done_next;
    logic [ADDR_BITS-1:0] issue_addr;
    logic [INDEX_BITS-1:0] issue_row;

    // scan return side
    logic                 rd_valid_reg, rd_valid_next;
    logic [ADDR_BITS-1:0] rd_addr_reg, rd_addr_next;
    logic [ENTRY_BITS-1:0] rd_data;
    logic [TAG_BITS-1:0]  rd_tag;
    logic [LOAD_BITS-1:0] rd_load;

    // search results
    logic                 found_reg, found_next;
    logic [ADDR_BITS-1:0] found_addr_reg, found_addr_next;
    logic [LOAD_BITS-1:0] found_load_reg, found_load_next;
    logic                 min_init_reg, min_init_next;
    logic [ADDR_BITS-1:0] min_addr_reg, min_addr_next;
    logic [LOAD_BITS-1:0] min_load_reg, min_load_next;

    // write-back and result
    logic [TAG_BITS-1:0]  query_tag;
    logic [ADDR_BITS-1:0] sel_addr;
    logic [LOAD_BITS-1:0] sel_load;
    logic                 sel_limited;
    logic                 res_limited_reg, res_limited_next;
    logic                 res_found_reg, res_found_next;
    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_data_reg, m_data_next;

    // memory ports
    logic                  ram_wr_en;
    logic [ADDR_BITS-1:0]  ram_wr_addr;
    logic [ENTRY_BITS-1:0] ram_wr_data;
    logic                  ram_rd_en;

    logic s_accept;
    logic out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'b0, m_data_reg};

    assign clear_last = (clear_addr_reg == ADDR_BITS'(STORE_DEPTH - 1));
    assign query_tag  = hash_reg[TAG_LSB +: TAG_BITS];

    // line address: (row * choices + line) * slots + slot
    assign issue_row  = (issue_line_reg == '0) ? hash_reg[INDEX_BITS-1:0]
                                               : hash_reg[2*INDEX_BITS-1:INDEX_BITS];
    assign issue_addr = (ADDR_BITS'(issue_row) * ADDR_BITS'(LINE_CHOICES)
                         + ADDR_BITS'(issue_line_reg)) * ADDR_BITS'(SLOTS_PER_LINE)
                        + ADDR_BITS'(issue_slot_reg);

    assign rd_tag  = rd_data[ENTRY_BITS-1:LOAD_BITS];
    assign rd_load = rd_data[LOAD_BITS-1:0];

    // hit slot wins, otherwise the first least-loaded slot
    assign sel_addr    = found_reg ? found_addr_reg : min_addr_reg;
    assign sel_load    = found_reg ? found_load_reg : min_load_reg;
    assign sel_limited = (sel_load >= limit16_reg);

    // shared multiplier for the generator step
    assign mul_prod = 64'(mul_a) * 64'(mul_b);

    always_comb
    begin
        case (state_reg)
            ST_RNG_X1:
            begin
                mul_a = rng_reg[63:32];
                mul_b = RNG_MUL[31:0];
            end
            ST_RNG_X2:
            begin
                mul_a = rng_reg[31:0];
                mul_b = RNG_MUL[63:32];
            end
            default:
            begin
                mul_a = rng_reg[31:0];
                mul_b = RNG_MUL[31:0];
            end
        endcase
    end

    // store ports
    always_comb
    begin
        ram_wr_en   = (state_reg == ST_CLEAR) || (state_reg == ST_WRITE);
        ram_wr_addr = (state_reg == ST_CLEAR) ? clear_addr_reg : sel_addr;
        ram_wr_data = '0;
        if (state_reg == ST_WRITE)
        begin
            ram_wr_data = {query_tag,
                           sel_limited ? sel_load : LOAD_BITS'(sel_load + price16_reg)};
        end
        ram_rd_en = (state_reg == ST_SCAN) && !issue_done_reg;
    end

    hhhl_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (issue_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    // generator only steps for a nonzero fraction
                    state_next = (s_tdata[79:64] != 16'd0) ? ST_RNG_LO : ST_SCAN;
                end
            end
            ST_RNG_LO:  state_next = ST_RNG_X1;
            ST_RNG_X1:  state_next = ST_RNG_X2;
            ST_RNG_X2:  state_next = ST_RNG_ADD;
            ST_RNG_ADD: state_next = ST_ROUND;
            ST_ROUND:   state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (issue_done_reg && rd_valid_reg)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:   state_next = ST_DONE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        hash_next        = hash_reg;
        price16_next     = price16_reg;
        limit16_next     = limit16_reg;
        fract_next       = fract_reg;
        rng_next         = rng_reg;
        acc_next         = acc_reg;
        clear_addr_next  = clear_addr_reg;
        issue_line_next  = issue_line_reg;
        issue_slot_next  = issue_slot_reg;
        issue_done_next  = issue_done_reg;
        rd_valid_next    = 1'b0;
        rd_addr_next     = rd_addr_reg;
        found_next       = found_reg;
        found_addr_next  = found_addr_reg;
        found_load_next  = found_load_reg;
        min_init_next    = min_init_reg;
        min_addr_next    = min_addr_reg;
        min_load_next    = min_load_reg;
        res_limited_next = res_limited_reg;
        res_found_next   = res_found_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_data_next      = m_data_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                clear_addr_next = clear_addr_reg + ADDR_BITS'(1);
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    hash_next       = s_tdata[63:0];
                    price16_next    = s_tdata[95:80];
                    limit16_next    = 16'd0 - s_tdata[95:80];
                    fract_next      = s_tdata[79:64];
                    issue_line_next = '0;
                    issue_slot_next = '0;
                    issue_done_next = 1'b0;
                    found_next      = 1'b0;
                    min_init_next   = 1'b0;
                end
            end
            ST_RNG_LO:
            begin
                acc_next = mul_prod;
            end
            ST_RNG_X1, ST_RNG_X2:
            begin
                // cross products only reach the upper word mod 2^64
                acc_next[63:32] = acc_reg[63:32] + mul_prod[31:0];
            end
            ST_RNG_ADD:
            begin
                rng_next = acc_reg + RNG_ADD;
            end
            ST_ROUND:
            begin
                if (rng_reg[63:48] < fract_reg)
                begin
                    price16_next = price16_reg + 16'd1;
                end
                limit16_next = limit16_reg - 16'd1;
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    rd_valid_next = 1'b1;
                    rd_addr_next  = issue_addr;
                    if (issue_slot_reg == SLOT_BITS'(SLOTS_PER_LINE - 1))
                    begin
                        issue_slot_next = '0;
                        if (issue_line_reg == LINE_BITS'(LINE_CHOICES - 1))
                        begin
                            issue_done_next = 1'b1;
                        end
                        else
                        begin
                            issue_line_next = issue_line_reg + LINE_BITS'(1);
                        end
                    end
                    else
                    begin
                        issue_slot_next = issue_slot_reg + SLOT_BITS'(1);
                    end
                end
                if (rd_valid_reg)
                begin
                    // first match in search order
                    if (!found_reg && (rd_tag == query_tag))
                    begin
                        found_next      = 1'b1;
                        found_addr_next = rd_addr_reg;
                        found_load_next = rd_load;
                    end
                    // first strictly smallest load
                    if (!min_init_reg || (rd_load < min_load_reg))
                    begin
                        min_init_next = 1'b1;
                        min_addr_next = rd_addr_reg;
                        min_load_next = rd_load;
                    end
                end
            end
            ST_WRITE:
            begin
                res_limited_next = sel_limited;
                res_found_next   = found_reg;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {res_found_reg, res_limited_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            rng_reg        <= RNG_SEED;
            clear_addr_reg <= '0;
            issue_done_reg <= 1'b0;
            rd_valid_reg   <= 1'b0;
            found_reg      <= 1'b0;
            min_init_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            rng_reg        <= rng_next;
            clear_addr_reg <= clear_addr_next;
            issue_done_reg <= issue_done_next;
            rd_valid_reg   <= rd_valid_next;
            found_reg      <= found_next;
            min_init_reg   <= min_init_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        hash_reg        <= hash_next;
        price16_reg     <= price16_next;
        limit16_reg     <= limit16_next;
        fract_reg       <= fract_next;
        acc_reg         <= acc_next;
        issue_line_reg  <= issue_line_next;
        issue_slot_reg  <= issue_slot_next;
        rd_addr_reg     <= rd_addr_next;
        found_addr_reg  <= found_addr_next;
        found_load_reg  <= found_load_next;
        min_addr_reg    <= min_addr_next;
        min_load_reg    <= min_load_next;
        res_limited_reg <= res_limited_next;
        res_found_reg   <= res_found_next;
        m_data_reg      <= m_data_next;
    end

endmodule

### rtl/hhhl_checker.sv
// ----------------------------------------------------------------------------
// hhhl_checker: port-level checks for the heavy-hitter limiter
// watches request acceptance and result delivery over time
// ----------------------------------------------------------------------------
module hhhl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [95:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata
);

    logic s_accept;

    assign s_accept = s_tvalid && s_tready;

    // one request in flight: busy right after taking one
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready
    ) else $error("s_tready high in the cycle after a request");

    // a request is searched first, so no result rises right after it
    a_no_instant_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        s_accept |=> !$rose(m_tvalid)
    ) else $error("result rose one cycle after a request");

    // padding bits of the result stay zero
    a_result_padding: assert property (
        @(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[7:2] == 6'd0)
    ) else $error("nonzero padding in m_tdata");

    // stalled result holds
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata))
    ) else $error("stalled result changed or dropped");

endmodule

bind hashed_heavy_hitter_limiter_unit hhhl_checker u_hhhl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### sim/hhhl_limit_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hhhl_limit_checker: verdict predictor and comparator for the limiter
// tracks its own slot store and rounding generator, checks every result
// ----------------------------------------------------------------------------
module hhhl_limit_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [95:0] s_tdata,   // key_hash [63:0], price [95:64]
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // limited [0], found [1], zero [7:2]
    output int          mismatch_count,
    output int          pending_count
);

    localparam int ROW_BITS   = 10;
    localparam int LINE_SLOTS = 15;
    localparam int TABLES     = 2;
    localparam int ROWS       = 1 << ROW_BITS;
    localparam int DEPTH      = ROWS * TABLES * LINE_SLOTS;
    localparam int TAG_SHIFT  = TABLES * ROW_BITS;

    localparam logic [63:0] GEN_SEED = 64'd3723796604792068981;
    localparam logic [63:0] GEN_MUL  = 64'd11737314301796036329;
    localparam logic [63:0] GEN_INC  = 64'd3107264277052274849;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic limited;
        logic found;
    } verdict_t;

    logic [15:0] tag_store  [DEPTH];
    logic [15:0] load_store [DEPTH];
    logic [63:0] round_gen;
    verdict_t    verdict_queue [$];
    int          fault_total;

    // updates the slot store and generator for one request, returns its verdict
    function automatic verdict_t predict_verdict(input logic [63:0] key_hash,
                                                 input logic [31:0] price);
        logic [15:0] tag;
        logic [15:0] cost;
        logic [15:0] limit;
        logic [15:0] frac;
        int unsigned base [TABLES];
        int unsigned at;
        int          li;
        int          si;
        verdict_t    v;

        tag     = key_hash[TAG_SHIFT +: 16];
        cost    = price[31:16];
        frac    = price[15:0];
        limit   = 16'd0 - cost;
        v.found = 1'b0;

        // random round-up of a fractional price
        if (frac != 16'd0)
        begin
            round_gen = round_gen * GEN_MUL + GEN_INC;
            if (round_gen[63:48] < frac)
                cost = cost + 16'd1;
            limit = limit - 16'd1;
        end

        for (li = 0; li < TABLES; li++)
            base[li] = (int'(key_hash[li * ROW_BITS +: ROW_BITS]) * TABLES + li) * LINE_SLOTS;

        // first matching tag, table 0 before table 1
        at = base[0];
        for (li = 0; li < TABLES; li++)
            for (si = 0; si < LINE_SLOTS; si++)
                if (!v.found && tag_store[base[li] + si] == tag)
                begin
                    at      = base[li] + si;
                    v.found = 1'b1;
                end

        // miss: first slot with the strictly smallest load takes the tag
        if (!v.found)
        begin
            for (li = 0; li < TABLES; li++)
                for (si = 0; si < LINE_SLOTS; si++)
                    if (load_store[base[li] + si] < load_store[at])
                        at = base[li] + si;
            tag_store[at] = tag;
        end

        v.limited = (load_store[at] >= limit);
        if (!v.limited)
            load_store[at] = load_store[at] + cost;
        return v;
    endfunction

    task automatic note_fault(input string what, input logic [7:0] want,
                              input logic [7:0] got);
        if (fault_total < REPORT_LIMIT)
            $display("[%0t] %s: expected %0h, got %0h", $time, what, want, got);
        fault_total++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        verdict_t want;
        int       i;
        if (!rst_n)
        begin
            for (i = 0; i < DEPTH; i++)
            begin
                tag_store[i]  = 16'd0;
                load_store[i] = 16'd0;
            end
            round_gen = GEN_SEED;
            verdict_queue.delete();
            fault_total     = 0;
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                verdict_queue.push_back(predict_verdict(s_tdata[63:0], s_tdata[95:64]));
            if (m_tvalid && m_tready)
            begin
                if (verdict_queue.size() == 0)
                    note_fault("result with no request pending", 8'h00, m_tdata);
                else
                begin
                    want = verdict_queue.pop_front();
                    if (m_tdata[0] !== want.limited)
                        note_fault("limited flag", 8'(want.limited), 8'(m_tdata[0]));
                    if (m_tdata[1] !== want.found)
                        note_fault("found flag", 8'(want.found), 8'(m_tdata[1]));
                    if (m_tdata[7:2] !== 6'd0)
                        note_fault("padding bits", 8'h00, 8'(m_tdata[7:2]));
                end
            end
            mismatch_count <= fault_total;
            pending_count  <= verdict_queue.size();
        end
    end

endmodule

### sim/tb_hashed_heavy_hitter_limiter_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hashed_heavy_hitter_limiter_unit: stimulus and verdict for the limiter
// directed corner requests, then random requests mostly aimed at a few shared
// lines so that slots fill, saturate and get taken over; a side checker predicts
// and checks every result
module tb_hashed_heavy_hitter_limiter_unit;

    localparam int RANDOM_QUERIES = 800;
    localparam int NOISE_PERCENT  = 15;
    localparam int TAG_POOL       = 48;
    localparam int ROW_MAX        = 1023;
    localparam int MAX_GAP        = 12;
    // covers the clearing pass, then each request with its sender gaps and
    // receiver stalls; taken several times over
    localparam int CYCLE_LIMIT    = 500000;
    // idle tail after the final drain, outlasts the longest request from accept to result
    localparam int TAIL_CYCLES    = 60;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // key_hash [63:0], price [95:64]
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // limited [0], found [1], zero [7:2]

    int          mismatch_count;
    int          pending_count;
    int          cycle_count;
    logic        send_calm;

    // small pools of rows and tags make requests collide on the same lines
    logic [15:0] tag_pool  [TAG_POOL];
    logic [9:0]  row0_pool [3];
    logic [9:0]  row1_pool [3];

    hashed_heavy_hitter_limiter_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hhhl_limit_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit: a hang anywhere ends here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one request: optional idle gap, then hold it until accepted
    task automatic send_query(input logic [63:0] key_hash, input logic [31:0] price);
        int gap;
        gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {price, key_hash};
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
    endtask

    // stop sending until every predicted result has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
    endtask

    // key on the shared lines with a pooled tag; the unused top bits are random
    function automatic logic [63:0] draw_pool_key();
        logic [31:0] spare;
        spare = $urandom;
        return {spare[27:0], tag_pool[$urandom_range(0, TAG_POOL - 1)],
                row1_pool[$urandom_range(0, 2)], row0_pool[$urandom_range(0, 2)]};
    endfunction

    // price mix: zero integer part, heavy prices that saturate a slot in a
    // few hits, light prices, and fully random ones; fraction often zero
    function automatic logic [31:0] draw_price();
        logic [15:0] whole;
        logic [15:0] frac;
        logic [31:0] raw;
        int          pick;
        pick = $urandom_range(0, 9);
        frac = $urandom_range(0, 1) ? 16'($urandom_range(0, 65535)) : 16'd0;
        raw  = $urandom;
        if (pick == 0)
            whole = 16'd0;
        else if (pick <= 4)
            whole = 16'($urandom_range(16'h4000, 16'hFFFF));
        else if (pick <= 8)
            whole = 16'($urandom_range(0, 16'h00FF));
        else
        begin
            whole = raw[31:16];
            frac  = raw[15:0];
        end
        return {whole, frac};
    endfunction

    // receiver: after each accepted result, maybe stall the next one for a
    // random count once it shows up; calm stretches keep m_tready high
    initial
    begin
        int   stall;
        int   calm_left;
        logic calm;
        calm_left = 0;
        calm      = 1'b0;
        m_tready <= 1'b1;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (calm_left == 0)
                begin
                    calm_left = $urandom_range(10, 40);
                    calm      = ($urandom_range(0, 3) == 0);
                end
                calm_left--;
                stall = calm ? 0 : $urandom_range(0, MAX_GAP);
                if (stall > 0)
                begin
                    m_tready <= 1'b0;
                    do
                        @(posedge clk);
                    while (!m_tvalid);
                    repeat (stall - 1) @(posedge clk);
                    m_tready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        logic [63:0] key_a;
        logic [63:0] key_b;
        logic [63:0] key_c;
        int          n;

        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        send_calm  = 1'b0;

        tag_pool[0] = 16'h0000;
        tag_pool[1] = 16'hFFFF;
        for (n = 2; n < TAG_POOL; n++)
            tag_pool[n] = 16'($urandom_range(1, 16'hFFFE));
        row0_pool[0] = 10'd0;
        row0_pool[1] = 10'(ROW_MAX);
        row0_pool[2] = 10'($urandom_range(1, ROW_MAX - 1));
        row1_pool[0] = 10'd0;
        row1_pool[1] = 10'(ROW_MAX);
        row1_pool[2] = 10'($urandom_range(1, ROW_MAX - 1));

        // fixed keys on otherwise unused rows: {tag, row1, row0}
        key_a = {28'd0, 16'h1234, 10'd5, 10'd6};
        key_b = {28'd0, 16'h5678, 10'd9, 10'd8};
        key_c = {28'd0, 16'h9ABC, 10'd9, 10'd8};

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ---- directed part ----
        // tag zero on rows zero matches a never-used slot; zero price always limits
        send_query(64'd0, 32'h0000_0000);
        // all-ones key: tag ffff on the top rows, full fraction steps the generator
        send_query(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        // whole ffff without fraction: limit one, load has room only when empty
        send_query(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_0000);
        // half-range price: the second hit on the same tag reaches the limit
        send_query(key_a, 32'h8000_0000);
        send_query(key_a, 32'h8000_0000);
        // fraction-only prices, smallest and largest fraction, then a whole one
        send_query(key_a, 32'h0000_0001);
        send_query(key_a, 32'h0000_FFFF);
        send_query(key_a, 32'h0001_0000);
        // miss that gets limited: tag still takes the slot, load stays zero
        send_query(key_b, 32'h0000_0000);
        send_query(key_b, 32'h0100_0000);
        // another miss on the same lines takes the first least-loaded slot
        send_query(key_c, 32'h0200_8000);
        send_query(key_c, 32'hFF00_0000);
        send_query(key_b, 32'h0001_0000);
        // tag zero against a line where slots are still free
        send_query({28'hFFF_FFFF, 16'h0000, 10'd9, 10'd8}, 32'h0001_0000);
        // large price, then a small one, on the slot the all-ones key has loaded: both limit
        send_query({28'd0, 16'hFFFF, 10'd0, 10'(ROW_MAX)}, 32'hFFFE_0000);
        send_query({28'd0, 16'hFFFF, 10'd0, 10'(ROW_MAX)}, 32'h0002_0000);

        // result pressure: sender waits for every outstanding result
        drain_results();

        // ---- random part ----
        for (n = 0; n < RANDOM_QUERIES; n++)
        begin
            if (n % 40 == 0)
                send_calm = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_QUERIES / 2)
                drain_results();
            if ($urandom_range(0, 99) < NOISE_PERCENT)
                send_query({$urandom, $urandom}, $urandom);
            else
                send_query(draw_pool_key(), draw_price());
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### filelist.f
rtl/hhhl_pkg.sv
rtl/hhhl_ram.sv
rtl/hashed_heavy_hitter_limiter_unit.sv
rtl/hhhl_checker.sv
sim/hhhl_limit_checker.sv
sim/tb_hashed_heavy_hitter_limiter_unit.sv
